// ----- sv/iqs_pkg.sv -----
package iqs_pkg;

   localparam int IQS_DATA_W = 32;

   typedef enum logic [1:0] {
      RA_I,
      RA_J,
      RA_LO,
      RA_K
   } iqs_raddr_type;

   typedef enum logic [1:0] {
      WS_I_RD,
      WS_J_A,
      WS_LO_RD,
      WS_J_PIV
   } iqs_wsel_type;

   typedef enum logic [1:0] {
      PS_INIT,
      PS_RIGHT,
      PS_LEFT
   } iqs_psel_type;

   typedef struct packed {
      logic          load;
      logic          push;
      iqs_psel_type  push_sel;
      logic          pop;
      logic          take_range;
      logic          take_pivot;
      logic          rd_en;
      iqs_raddr_type raddr_sel;
      logic          wr_en;
      iqs_wsel_type  wr_sel;
      logic          i_inc;
      logic          j_dec;
      logic          a_save;
      logic          k_clr;
      logic          k_inc;
      logic          out_load;
      logic          out_clr;
      logic          run_end;
   } iqs_cmd_type;

   typedef struct packed {
      logic i_lt_j;
      logic j_gt_lo;
      logic key_lt;
      logic key_gt;
      logic right_ok;
      logic left_ok;
      logic sp_zero;
      logic count_ge2;
      logic k_last;
   } iqs_status_type;

endpackage

// ----- sv/iqs_ctrl.sv -----
module iqs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_final_item,
   input  logic                    rsp_stall,
   input  iqs_pkg::iqs_status_type status,
   output logic                    req_stall,
   output iqs_pkg::iqs_cmd_type    cmd
);
   import iqs_pkg::*;

   typedef enum logic [4:0] {
      S_LOAD,
      S_START,
      S_POP,
      S_RANGE,
      S_PIV,
      S_LOOP,
      S_RDI,
      S_CMPI,
      S_RDJ,
      S_CMPJ,
      S_CHK,
      S_SWB,
      S_FIN,
      S_FINC,
      S_FINR,
      S_SW1,
      S_SW2,
      S_PUSHR,
      S_PUSHL,
      S_ORD,
      S_OLD,
      S_OHOLD
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != S_LOAD);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.push_sel = PS_INIT;
      cmd.raddr_sel = RA_I;
      cmd.wr_sel = WS_I_RD;
      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_final_item) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            cmd.k_clr = 1'b1;
            if (status.count_ge2) begin
               cmd.push = 1'b1;
               cmd.push_sel = PS_INIT;
               state_in = S_POP;
            end else begin
               state_in = S_ORD;
            end
         end
         S_POP: begin
            if (status.sp_zero) begin
               cmd.k_clr = 1'b1;
               state_in = S_ORD;
            end else begin
               cmd.pop = 1'b1;
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            cmd.take_range = 1'b1;
            cmd.rd_en = 1'b1;
            cmd.raddr_sel = RA_LO;
            state_in = S_PIV;
         end
         S_PIV: begin
            cmd.take_pivot = 1'b1;
            state_in = S_LOOP;
         end
         S_LOOP: begin
            state_in = status.i_lt_j ? S_RDI : S_FIN;
         end
         S_RDI: begin
            if (status.i_lt_j) begin
               cmd.rd_en = 1'b1;
               cmd.raddr_sel = RA_I;
               state_in = S_CMPI;
            end else begin
               state_in = S_RDJ;
            end
         end
         S_CMPI: begin
            if (status.key_lt) begin
               cmd.i_inc = 1'b1;
               state_in = S_RDI;
            end else begin
               cmd.a_save = 1'b1;
               state_in = S_RDJ;
            end
         end
         S_RDJ: begin
            if (status.j_gt_lo) begin
               cmd.rd_en = 1'b1;
               cmd.raddr_sel = RA_J;
               state_in = S_CMPJ;
            end else begin
               state_in = S_CHK;
            end
         end
         S_CMPJ: begin
            if (status.key_gt) begin
               cmd.j_dec = 1'b1;
               state_in = S_RDJ;
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (status.i_lt_j) begin
               cmd.wr_en = 1'b1;
               cmd.wr_sel = WS_I_RD;
               state_in = S_SWB;
            end else begin
               state_in = S_FIN;
            end
         end
         S_SWB: begin
            cmd.wr_en = 1'b1;
            cmd.wr_sel = WS_J_A;
            cmd.i_inc = 1'b1;
            cmd.j_dec = 1'b1;
            state_in = S_LOOP;
         end
         S_FIN: begin
            cmd.rd_en = 1'b1;
            cmd.raddr_sel = RA_J;
            state_in = S_FINC;
         end
         S_FINC: begin
            if (status.j_gt_lo && status.key_gt) begin
               cmd.j_dec = 1'b1;
               state_in = S_FINR;
            end else begin
               state_in = S_SW1;
            end
         end
         S_FINR: begin
            cmd.rd_en = 1'b1;
            cmd.raddr_sel = RA_J;
            state_in = S_SW1;
         end
         S_SW1: begin
            cmd.wr_en = 1'b1;
            cmd.wr_sel = WS_LO_RD;
            state_in = S_SW2;
         end
         S_SW2: begin
            cmd.wr_en = 1'b1;
            cmd.wr_sel = WS_J_PIV;
            state_in = S_PUSHR;
         end
         S_PUSHR: begin
            if (status.right_ok) begin
               cmd.push = 1'b1;
               cmd.push_sel = PS_RIGHT;
            end
            state_in = S_PUSHL;
         end
         S_PUSHL: begin
            if (status.left_ok) begin
               cmd.push = 1'b1;
               cmd.push_sel = PS_LEFT;
            end
            state_in = S_POP;
         end
         S_ORD: begin
            cmd.rd_en = 1'b1;
            cmd.raddr_sel = RA_K;
            state_in = S_OLD;
         end
         S_OLD: begin
            cmd.out_load = 1'b1;
            state_in = S_OHOLD;
         end
         S_OHOLD: begin
            if (!rsp_stall) begin
               cmd.out_clr = 1'b1;
               if (status.k_last) begin
                  cmd.run_end = 1'b1;
                  cmd.k_clr = 1'b1;
                  state_in = S_LOAD;
               end else begin
                  cmd.k_inc = 1'b1;
                  state_in = S_ORD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sv/iqs_datapath.sv -----
module iqs_datapath #(
   parameter int MAX_LEN     = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  iqs_pkg::iqs_cmd_type                cmd,
   input  logic signed [iqs_pkg::IQS_DATA_W-1:0] req_value,
   output iqs_pkg::iqs_status_type             status,
   output logic                                rsp_valid,
   output logic signed [iqs_pkg::IQS_DATA_W-1:0] rsp_sorted_value,
   output logic                                rsp_last_out,
   output logic                                rsp_overflow
);
   import iqs_pkg::*;

   localparam int IW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW    = $clog2(MAX_LEN + 1);
   localparam int DEPTH = MAX_LEN / 2;
   localparam int SW    = $clog2(DEPTH + 1);
   localparam int SIW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int KW    = (VALUE_WIDTH > IQS_DATA_W) ? IQS_DATA_W : VALUE_WIDTH;
   localparam bit SIGNED_CMP = (VALUE_WIDTH <= IQS_DATA_W);

   // compare key: low bits with sign flipped, or plain unsigned when wider
   function automatic logic [IQS_DATA_W-1:0] order_key(input logic [IQS_DATA_W-1:0] v);
      logic [IQS_DATA_W-1:0] k;
      k = IQS_DATA_W'(v[KW-1:0]);
      if (SIGNED_CMP) begin
         k[KW-1] = ~k[KW-1];
      end
      return k;
   endfunction

   logic [IQS_DATA_W-1:0] store_mem [MAX_LEN];
   logic [2*IW-1:0]       stack_mem [DEPTH];

   logic [CW-1:0]         count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic [SW-1:0]         sp_ff, sp_in;
   logic [IW-1:0]         lo_ff, lo_in;
   logic [IW-1:0]         hi_ff, hi_in;
   logic [IW-1:0]         i_ff, i_in;
   logic [IW-1:0]         j_ff, j_in;
   logic [IW-1:0]         k_ff, k_in;
   logic [IQS_DATA_W-1:0] pivot_ff, pivot_in;
   logic [IQS_DATA_W-1:0] a_ff, a_in;
   logic [IQS_DATA_W-1:0] rd_ff;
   logic [2*IW-1:0]       stack_rd_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [IQS_DATA_W-1:0] out_value_ff, out_value_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_ovf_ff, out_ovf_in;

   logic                  room;
   logic [CW-1:0]         cnt_m1;
   logic [SW-1:0]         sp_m1;
   logic [IW-1:0]         i_p1, j_p1, j_m1, lo_p1, k_p1;
   logic [IW-1:0]         stk_lo, stk_hi;
   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   logic [IQS_DATA_W-1:0] wr_data;
   logic [IW-1:0]         rd_addr;
   logic                  push_en;
   logic [2*IW-1:0]       push_data;
   logic [IW:0]           j_p2_wide, lo_p2_wide;

   assign room     = count_ff < CW'(MAX_LEN);
   assign cnt_m1   = count_ff - 1'b1;
   assign sp_m1    = sp_ff - 1'b1;
   assign i_p1     = i_ff + 1'b1;
   assign j_p1     = j_ff + 1'b1;
   assign j_m1     = j_ff - 1'b1;
   assign lo_p1    = lo_ff + 1'b1;
   assign k_p1     = k_ff + 1'b1;
   assign stk_lo   = stack_rd_ff[IW-1:0];
   assign stk_hi   = stack_rd_ff[2*IW-1:IW];
   assign j_p2_wide  = {1'b0, j_ff} + (IW+1)'(2);
   assign lo_p2_wide = {1'b0, lo_ff} + (IW+1)'(2);

   assign status.i_lt_j    = i_ff < j_ff;
   assign status.j_gt_lo   = j_ff > lo_ff;
   assign status.key_lt    = order_key(rd_ff) < order_key(pivot_ff);
   assign status.key_gt    = order_key(rd_ff) > order_key(pivot_ff);
   assign status.right_ok  = j_p2_wide <= {1'b0, hi_ff};
   assign status.left_ok   = lo_p2_wide <= {1'b0, j_ff};
   assign status.sp_zero   = sp_ff == '0;
   assign status.count_ge2 = count_ff >= CW'(2);
   assign status.k_last    = k_ff == cnt_m1[IW-1:0];

   // element store port muxing
   always_comb begin
      wr_en   = (cmd.load && room) || cmd.wr_en;
      wr_addr = count_ff[IW-1:0];
      wr_data = req_value;
      if (!cmd.load) begin
         case (cmd.wr_sel)
            WS_I_RD: begin
               wr_addr = i_ff;
               wr_data = rd_ff;
            end
            WS_J_A: begin
               wr_addr = j_ff;
               wr_data = a_ff;
            end
            WS_LO_RD: begin
               wr_addr = lo_ff;
               wr_data = rd_ff;
            end
            WS_J_PIV: begin
               wr_addr = j_ff;
               wr_data = pivot_ff;
            end
            default: begin
               wr_addr = i_ff;
               wr_data = rd_ff;
            end
         endcase
      end
      case (cmd.raddr_sel)
         RA_I:    rd_addr = i_ff;
         RA_J:    rd_addr = j_ff;
         RA_LO:   rd_addr = stk_lo;
         RA_K:    rd_addr = k_ff;
         default: rd_addr = i_ff;
      endcase
   end

   // range stack push
   always_comb begin
      push_en = cmd.push && (sp_ff < SW'(DEPTH));
      case (cmd.push_sel)
         PS_INIT:  push_data = {cnt_m1[IW-1:0], IW'(0)};
         PS_RIGHT: push_data = {hi_ff, j_p1};
         PS_LEFT:  push_data = {j_m1, lo_ff};
         default:  push_data = {hi_ff, lo_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_mem[sp_ff[SIW-1:0]] <= push_data;
      end
      if (cmd.pop) begin
         stack_rd_ff <= stack_mem[sp_m1[SIW-1:0]];
      end
   end

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      sp_in        = sp_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      pivot_in     = pivot_ff;
      a_in         = a_ff;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;

      if (cmd.load) begin
         if (room) begin
            count_in = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (push_en) begin
         sp_in = sp_ff + 1'b1;
      end
      if (cmd.pop) begin
         sp_in = sp_m1;
      end
      if (cmd.take_range) begin
         lo_in = stk_lo;
         hi_in = stk_hi;
      end
      if (cmd.take_pivot) begin
         pivot_in = rd_ff;
         i_in     = lo_p1;
         j_in     = hi_ff;
      end
      if (cmd.i_inc) begin
         i_in = i_p1;
      end
      if (cmd.j_dec) begin
         j_in = j_m1;
      end
      if (cmd.a_save) begin
         a_in = rd_ff;
      end
      if (cmd.k_inc) begin
         k_in = k_p1;
      end
      if (cmd.k_clr) begin
         k_in = '0;
      end
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
         out_value_in = rd_ff;
         out_last_in  = status.k_last;
         out_ovf_in   = ovf_ff;
      end
      if (cmd.out_clr) begin
         out_valid_in = 1'b0;
      end
      if (cmd.run_end) begin
         count_in = '0;
         ovf_in   = 1'b0;
         sp_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         sp_ff        <= '0;
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         sp_ff        <= sp_in;
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      pivot_ff     <= pivot_in;
      a_ff         <= a_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_sorted_value = out_value_ff;
   assign rsp_last_out     = out_last_ff;
   assign rsp_overflow     = out_ovf_ff;

endmodule

// ----- sv/integer_quicksort_engine.sv -----
// integer quicksort engine
// req channel: one signed value per beat, req_final_item high on the last
// beat of a list. up to MAX_LEN values are kept; further beats are dropped
// and the run is marked with rsp_overflow, but a dropped final beat still
// ends the run. while loading, every beat with req_valid high is taken.
// after the final beat req_stall goes high and the list is sorted in place,
// ascending, with first-element pivots and an explicit range stack. the
// scan and the pivot placement go through the one read port and the one
// write port of the element store; an already ordered list is a slow case.
// rsp channel: the sorted values come out in order, each read from the
// store into a register before it is shown; rsp_valid drops between beats
// and rsp_last_out marks the last one. while rsp_stall is high the current
// beat holds. after the last beat the block takes a new list.
// reset empties the list and the stack and clears the overflow mark;
// stored values are not cleared.
module integer_quicksort_engine #(
   parameter int MAX_LEN     = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [iqs_pkg::IQS_DATA_W-1:0] req_value,
   input  logic                                  req_final_item,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [iqs_pkg::IQS_DATA_W-1:0] rsp_sorted_value,
   output logic                                  rsp_last_out,
   output logic                                  rsp_overflow
);
   import iqs_pkg::*;

   iqs_cmd_type    cmd;
   iqs_status_type status;

   iqs_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_final_item (req_final_item),
      .rsp_stall      (rsp_stall),
      .status         (status),
      .req_stall      (req_stall),
      .cmd            (cmd)
   );

   iqs_datapath #(
      .MAX_LEN     (MAX_LEN),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_value        (req_value),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow)
   );

endmodule
